### sv/sst_pkg.sv
// Package for the seat session table: widths, register indexes, status codes,
// item types and the command and status structs between controller and datapath.
// Depends on nothing.
package sst_pkg;

  // Table size and derived widths.
  localparam int SLOTS   = 16;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int MAXS_W  = 5;
  localparam int CMP_W   = (CNT_W > MAXS_W) ? CNT_W : MAXS_W;

  // Field widths.
  localparam int USER_W    = 32;
  localparam int TIME_W    = 32;
  localparam int YEAR_W    = 14;
  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 5;
  localparam int TMO_W     = 16;
  localparam int STATUS_W  = 2;
  localparam int SLOTOUT_W = 4;
  localparam int ENTRY_W   = USER_W + TIME_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SESSIONS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY_YEAR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY_MONTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY_DAY   = 3'd4;

  // Register reset values.
  localparam logic [MAXS_W-1:0]  RST_MAX_SESSIONS = 5'd1;
  localparam logic [TMO_W-1:0]   RST_IDLE_TIMEOUT = 16'd600;
  localparam logic [YEAR_W-1:0]  RST_EXPIRY_YEAR  = 14'd0;
  localparam logic [MONTH_W-1:0] RST_EXPIRY_MONTH = 4'd12;
  localparam logic [DAY_W-1:0]   RST_EXPIRY_DAY   = 5'd31;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_GRANTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DENIED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXPIRED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOINIT  = 2'd3;

  // Which slot a table write goes to.
  typedef enum logic [1:0] {
    WR_HIT,
    WR_REUSE,
    WR_CREATE
  } sst_wr_e;

  typedef struct packed {
    logic [USER_W-1:0]  user_id;
    logic [TIME_W-1:0]  now_seconds;
    logic [YEAR_W-1:0]  today_year;
    logic [MONTH_W-1:0] today_month;
    logic [DAY_W-1:0]   today_day;
  } sst_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [SLOTOUT_W-1:0] slot_index;
  } sst_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic                load_item;
    logic                scan_init;
    logic                issue;
    logic                wr_en;
    sst_wr_e             wr_sel;
    logic                res_load;
    logic [STATUS_W-1:0] res_status;
    logic                out_load;
  } sst_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic noinit;
    logic expired;
    logic more;
    logic rd_pending;
    logic hit;
    logic have_exp;
    logic can_create;
  } sst_stat_t;

endpackage

### sv/sst_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                            wr_data_i,
  input  logic                                        rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                            rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

### sv/sst_dp.sv
// Datapath of the seat session table: item and configuration registers, the
// slot RAM, the scan address and candidate tracking, and the result registers.
// Depends on sst_pkg and sst_ram.
module sst_dp import sst_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sst_in_t               in_item_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  sst_cmd_t              cmd_i,
  output sst_stat_t             stat_o,
  output sst_out_t              out_item_o
);

  sst_in_t              item_q;
  logic [MAXS_W-1:0]    max_sessions_q;
  logic [TMO_W-1:0]     idle_timeout_q;
  logic [YEAR_W-1:0]    expiry_year_q;
  logic [MONTH_W-1:0]   expiry_month_q;
  logic [DAY_W-1:0]     expiry_day_q;

  logic [CNT_W-1:0]     created_q;
  logic [CNT_W-1:0]     k_q;
  logic                 rd_vld_q;
  logic [IDX_W-1:0]     rd_addr_q;
  logic                 have_exp_q;
  logic [IDX_W-1:0]     exp_slot_q;
  logic [STATUS_W-1:0]  res_status_q;
  logic [IDX_W-1:0]     res_slot_q;
  sst_out_t             out_q;

  logic [CNT_W-1:0]     rd_addr_full;
  logic [IDX_W-1:0]     rd_addr;
  logic [ENTRY_W-1:0]   rd_data;
  logic [USER_W-1:0]    rd_user;
  logic [TIME_W-1:0]    rd_last;
  logic [TIME_W:0]      expire_at;
  logic [TIME_W:0]      now_ext;
  logic                 active;
  logic                 reusable;
  logic [CMP_W-1:0]     created_ext;
  logic [CMP_W-1:0]     max_ext;
  logic [CMP_W-1:0]     examined_ext;
  logic [CNT_W-1:0]     examined;
  logic [IDX_W-1:0]     wr_slot;
  logic [SLOTOUT_W+IDX_W-1:0] slot_ext;

  // Item capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_item_i;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_sessions_q <= RST_MAX_SESSIONS;
      idle_timeout_q <= RST_IDLE_TIMEOUT;
      expiry_year_q  <= RST_EXPIRY_YEAR;
      expiry_month_q <= RST_EXPIRY_MONTH;
      expiry_day_q   <= RST_EXPIRY_DAY;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MAX_SESSIONS: max_sessions_q <= cfg_data_i[MAXS_W-1:0];
        CFG_IDLE_TIMEOUT: idle_timeout_q <= cfg_data_i[TMO_W-1:0];
        CFG_EXPIRY_YEAR:  expiry_year_q  <= cfg_data_i[YEAR_W-1:0];
        CFG_EXPIRY_MONTH: expiry_month_q <= cfg_data_i[MONTH_W-1:0];
        CFG_EXPIRY_DAY:   expiry_day_q   <= cfg_data_i[DAY_W-1:0];
        default: ;
      endcase
    end
  end

  // License date checks on the captured item.
  assign stat_o.noinit  = (expiry_year_q == '0);
  assign stat_o.expired = (item_q.today_year > expiry_year_q) ||
                          ((item_q.today_year == expiry_year_q) &&
                           ((item_q.today_month > expiry_month_q) ||
                            ((item_q.today_month == expiry_month_q) &&
                             (item_q.today_day > expiry_day_q))));

  // Only the newest min(created, max_sessions) slots take part in the scan.
  assign created_ext  = CMP_W'(created_q);
  assign max_ext      = CMP_W'(max_sessions_q);
  assign examined_ext = (created_ext < max_ext) ? created_ext : max_ext;
  assign examined     = examined_ext[CNT_W-1:0];
  assign stat_o.more       = (k_q < examined);
  assign stat_o.rd_pending = rd_vld_q;
  assign stat_o.can_create = (created_ext < max_ext) && (created_q < CNT_W'(SLOTS));
  assign stat_o.have_exp   = have_exp_q;

  // Scan walks from the newest slot downward.
  assign rd_addr_full = created_q - CNT_W'(1) - k_q;
  assign rd_addr      = rd_addr_full[IDX_W-1:0];

  // Slot evaluation on the read data, 33-bit sum so nothing wraps.
  assign rd_user   = rd_data[ENTRY_W-1:TIME_W];
  assign rd_last   = rd_data[TIME_W-1:0];
  assign expire_at = {1'b0, rd_last} + (TIME_W + 1)'(idle_timeout_q);
  assign now_ext   = {1'b0, item_q.now_seconds};
  assign active    = (expire_at > now_ext);
  assign reusable  = (expire_at < now_ext);
  assign stat_o.hit = rd_vld_q && active && (rd_user == item_q.user_id);

  // Scan counter, read pipeline and newest reusable slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q        <= '0;
      rd_vld_q   <= 1'b0;
      have_exp_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.issue;
      if (cmd_i.scan_init) begin
        k_q        <= '0;
        have_exp_q <= 1'b0;
      end else begin
        if (cmd_i.issue) begin
          k_q <= k_q + CNT_W'(1);
        end
        if (rd_vld_q && reusable && !have_exp_q) begin
          have_exp_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rd_addr_q <= rd_addr;
    end
    if (rd_vld_q && reusable && !have_exp_q) begin
      exp_slot_q <= rd_addr_q;
    end
  end

  // Target slot of a table write.
  always_comb begin
    case (cmd_i.wr_sel)
      WR_HIT:    wr_slot = rd_addr_q;
      WR_REUSE:  wr_slot = exp_slot_q;
      WR_CREATE: wr_slot = created_q[IDX_W-1:0];
      default:   wr_slot = '0;
    endcase
  end

  // Slot count grows with every created slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      created_q <= '0;
    end else if (cmd_i.wr_en && (cmd_i.wr_sel == WR_CREATE)) begin
      created_q <= created_q + CNT_W'(1);
    end
  end

  sst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.wr_en),
    .wr_addr_i (wr_slot),
    .wr_data_i ({item_q.user_id, item_q.now_seconds}),
    .rd_en_i   (cmd_i.issue),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Result and output registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_slot_q   <= (cmd_i.res_status == ST_GRANTED) ? wr_slot : '0;
    end
    if (cmd_i.out_load) begin
      out_q.status     <= res_status_q;
      out_q.slot_index <= slot_ext[SLOTOUT_W-1:0];
    end
  end

  assign slot_ext   = (SLOTOUT_W + IDX_W)'(res_slot_q);
  assign out_item_o = out_q;

endmodule

### sv/sst_ctrl.sv
// Controller of the seat session table: sequences date check, slot scan,
// table write and result hand-off, and owns the handshake flags.
// Depends on sst_pkg.
module sst_ctrl import sst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  sst_stat_t stat_i,
  output sst_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Next state and commands.
  always_comb begin
    state_d          = state_q;
    cmd_o.load_item  = 1'b0;
    cmd_o.scan_init  = 1'b0;
    cmd_o.issue      = 1'b0;
    cmd_o.wr_en      = 1'b0;
    cmd_o.wr_sel     = WR_HIT;
    cmd_o.res_load   = 1'b0;
    cmd_o.res_status = ST_DENIED;
    cmd_o.out_load   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.noinit) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_NOINIT;
          state_d          = S_DONE;
        end else if (stat_i.expired) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_EXPIRED;
          state_d          = S_DONE;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d         = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.hit) begin
          // Active slot of this user: refresh it.
          cmd_o.wr_en      = 1'b1;
          cmd_o.wr_sel     = WR_HIT;
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_GRANTED;
          state_d          = S_DONE;
        end else if (stat_i.more) begin
          cmd_o.issue = 1'b1;
        end else if (!stat_i.rd_pending) begin
          // Scan finished without a hit: reuse, create or deny.
          cmd_o.res_load = 1'b1;
          state_d        = S_DONE;
          if (stat_i.have_exp) begin
            cmd_o.wr_en      = 1'b1;
            cmd_o.wr_sel     = WR_REUSE;
            cmd_o.res_status = ST_GRANTED;
          end else if (stat_i.can_create) begin
            cmd_o.wr_en      = 1'b1;
            cmd_o.wr_sel     = WR_CREATE;
            cmd_o.res_status = ST_GRANTED;
          end else begin
            cmd_o.res_status = ST_DENIED;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid flag: set on load, cleared when the item is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The table is written only when the scan concludes.
  a_wr_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_en |-> (state_q == S_SCAN))
    else $error("table write outside the scan");

  // No read is issued past the examined slots.
  a_issue_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |-> stat_i.more)
    else $error("slot read beyond the examined range");

  // A hit during the scan ends it at once.
  a_hit_ends_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && stat_i.hit) |=> (state_q == S_DONE))
    else $error("scan continued after a hit");

  // A loaded result is presented in the following cycle.
  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("result loaded but not presented");

endmodule

### sv/seat_session_table.sv
// Seat session table: grants, refreshes or denies session slots per user request.
// An uninitialized block or an expired license ends an item after the date check; otherwise
// the scan examines min(slots created, max_sessions) slots, at most 16 with 16 slots;
// the scan reads one slot per cycle through the single read port of the slot RAM, newest
// slot first, and stops at the first active slot of the requesting user. The finished
// result sits in an output register, so the next item is accepted while it waits.
// Configuration is to be written through the cfg port only while the block is idle;
// the user must keep to this, as the block itself does not enforce it.
module seat_session_table import sst_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sst_in_t               in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sst_out_t              out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  sst_cmd_t  cmd;
  sst_stat_t stat;

  // Register writes are always taken.
  assign cfg_ready_o = 1'b1;

  sst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sst_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_item_o  (out_item_o)
  );

endmodule
